/* hdl/vsmt_pkg.sv */
// shared types, constants and register codes for the voxel shape membership test
package vsmt_pkg;

  // fixed field widths
  localparam int GRID_W    = 6;
  localparam int POS_W     = 5;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 6;

  // default largest grid edge
  localparam int MAX_GRID_DEF = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 2'd1;

  // grid size reset and lower clamp
  localparam logic [GRID_W-1:0] GRID_RST = 6'd16;
  localparam logic [GRID_W-1:0] GRID_MIN = 6'd3;

  // shape codes
  localparam logic [MODE_W-1:0] MODE_CUBE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SPHERE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CYLINDER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PYRAMID  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TORUS    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RING     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CROSS    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CUSTOM   = 3'd7;
  localparam logic [MODE_W-1:0] MODE_RST      = MODE_CUBE;

  // datapath widths
  localparam int SQ_W  = 12;  // squared doubled offsets and grid terms
  localparam int S_W   = 13;  // dx^2 + dz^2
  localparam int T_W   = 14;  // dx^2 + dy^2 + dz^2
  localparam int L_W   = 26;  // torus left term
  localparam int K_W   = 36;  // torus scale times c2^2
  localparam int LSQ_W = 52;
  localparam int RHS_W = 49;
  localparam int ARM_W = 11;
  localparam int RNG_W = 22;

  // exact rational coefficients
  localparam int TOR_L_T = 2500;     // weight on the squared radius
  localparam int TOR_L_C = 705;      // weight on c2^2
  localparam int TOR_K   = 9610000;  // 3100 squared
  localparam int RING_S  = 400;
  localparam int RING_C  = 121;
  localparam int ARM_MUL = 25;

  // stage 0: captured transaction and clamped config
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [GRID_W-1:0] n;
    logic [MODE_W-1:0] mode;
  } s0_t;

  // stage 1: doubled offset magnitudes
  typedef struct packed {
    logic [GRID_W-1:0] ax;
    logic [GRID_W-1:0] ay;
    logic [GRID_W-1:0] az;
    logic [GRID_W-1:0] c2;
    logic [GRID_W-1:0] n;
    logic [GRID_W-1:0] yrem;
    logic              inr;
    logic [MODE_W-1:0] mode;
  } s1_t;

  // stage 2: squares and the simple shape flags
  typedef struct packed {
    logic [SQ_W-1:0]   axsq;
    logic [SQ_W-1:0]   aysq;
    logic [SQ_W-1:0]   azsq;
    logic [SQ_W-1:0]   c2sq;
    logic [SQ_W-1:0]   nsq;
    logic              inr;
    logic              pyr;
    logic              crs;
    logic [MODE_W-1:0] mode;
  } s2_t;

  // stage 3: radial sums
  typedef struct packed {
    logic [S_W-1:0]    s;
    logic [T_W-1:0]    t;
    logic [SQ_W-1:0]   c2sq;
    logic [SQ_W-1:0]   nsq;
    logic              inr;
    logic              pyr;
    logic              crs;
    logic [MODE_W-1:0] mode;
  } s3_t;

  // stage 4: torus terms and the radial shape flags
  typedef struct packed {
    logic [L_W-1:0]    l;
    logic [K_W-1:0]    k;
    logic [S_W-1:0]    s;
    logic              inr;
    logic              pyr;
    logic              crs;
    logic              sph;
    logic              cyl;
    logic              rng;
    logic [MODE_W-1:0] mode;
  } s4_t;

  // stage 5: torus products
  typedef struct packed {
    logic [LSQ_W-1:0]  lsq;
    logic [RHS_W-1:0]  rhs;
    logic              inr;
    logic              pyr;
    logic              crs;
    logic              sph;
    logic              cyl;
    logic              rng;
    logic [MODE_W-1:0] mode;
  } s5_t;

endpackage

/* hdl/voxel_shape_membership_test_core.sv */
// top level: config registers, pipeline valid chain, shape select and output register
// input acceptance to out_valid runs through six stages and the output register
// one transaction per cycle unless out_stall; stages advance independently so bubbles squeeze out
// the widest stage is the torus product stage (26x26 and 36x13 multiplies)
// reset: grid_size = 16, shape_mode = cube, all pipeline valids cleared
module voxel_shape_membership_test_core #(
  parameter int MAX_GRID = vsmt_pkg::MAX_GRID_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vsmt_pkg::POS_W-1:0]      in_pos_x,
  input  logic [vsmt_pkg::POS_W-1:0]      in_pos_y,
  input  logic [vsmt_pkg::POS_W-1:0]      in_pos_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_inside_res,
  input  logic                            cfg_we,
  input  logic [vsmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsmt_pkg::CFG_W-1:0]      cfg_data
);
  import vsmt_pkg::*;

  localparam int NST = 6;

  logic [GRID_W-1:0] grid_size_r;
  logic [MODE_W-1:0] shape_mode_r;
  logic [NST-1:0]    vld_r, vld_nxt;
  logic [NST-1:0]    en;
  logic              out_en;
  logic              out_valid_r;
  logic              inside_r, inside_nxt;
  logic              hit;
  logic              tor;
  s1_t               s1;
  s3_t               s3;
  s5_t               s5;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= GRID_RST;
      shape_mode_r <= MODE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_SIZE) begin
        grid_size_r <= cfg_data[GRID_W-1:0];
      end else if (cfg_index == REG_SHAPE_MODE) begin
        shape_mode_r <= cfg_data[MODE_W-1:0];
      end
    end
  end

  // per-stage advance: a stage loads when empty or when its successor loads
  always_comb begin
    out_en      = !out_valid_r || !out_stall;
    en[NST-1]   = !vld_r[NST-1] || out_en;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_stall = !en[0];

  vsmt_front #(
    .MAX_GRID (MAX_GRID)
  ) u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pos_z      (in_pos_z),
    .grid_size  (grid_size_r),
    .shape_mode (shape_mode_r),
    .s1         (s1)
  );

  vsmt_geom u_geom (
    .clk (clk),
    .en  (en[3:2]),
    .s1  (s1),
    .s3  (s3)
  );

  vsmt_torus u_torus (
    .clk (clk),
    .en  (en[5:4]),
    .s3  (s3),
    .s5  (s5)
  );

  // final torus compare and shape select
  always_comb begin
    tor = s5.lsq <= {3'd0, s5.rhs};
    case (s5.mode)
      MODE_CUBE:     hit = 1'b1;
      MODE_SPHERE:   hit = s5.sph;
      MODE_CYLINDER: hit = s5.cyl;
      MODE_PYRAMID:  hit = s5.pyr;
      MODE_TORUS:    hit = tor;
      MODE_RING:     hit = s5.rng;
      MODE_CROSS:    hit = s5.crs;
      MODE_CUSTOM:   hit = 1'b0;
      default:       hit = 1'b0;
    endcase
    inside_nxt = s5.inr && hit;
  end

  // valid chain and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (out_en) begin
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

endmodule

/* hdl/vsmt_front.sv */
// front stages: capture with grid clamp, then doubled offset magnitudes
module vsmt_front #(
  parameter int MAX_GRID = vsmt_pkg::MAX_GRID_DEF
) (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic [vsmt_pkg::POS_W-1:0]    pos_x,
  input  logic [vsmt_pkg::POS_W-1:0]    pos_y,
  input  logic [vsmt_pkg::POS_W-1:0]    pos_z,
  input  logic [vsmt_pkg::GRID_W-1:0]   grid_size,
  input  logic [vsmt_pkg::MODE_W-1:0]   shape_mode,
  output vsmt_pkg::s1_t                 s1
);
  import vsmt_pkg::*;

  localparam logic [GRID_W:0] MaxG = (GRID_W+1)'(MAX_GRID);

  s0_t               s0_r, s0_nxt;
  s1_t               s1_r, s1_nxt;
  logic [GRID_W-1:0] n_clamp;

  // |2p - (n-1)|, valid while p < n
  function automatic logic [GRID_W-1:0] dbl_abs(input logic [POS_W-1:0] p,
                                                input logic [GRID_W-1:0] n);
    logic signed [7:0] d;
    logic signed [7:0] m;
    d = $signed({2'b00, p, 1'b0}) - $signed({2'b00, n}) + 8'sd1;
    m = (d < 8'sd0) ? -d : d;
    return m[GRID_W-1:0];
  endfunction

  // clamp grid size to the supported range
  always_comb begin
    if (grid_size < GRID_MIN) begin
      n_clamp = GRID_MIN;
    end else if ({1'b0, grid_size} > MaxG) begin
      n_clamp = MaxG[GRID_W-1:0];
    end else begin
      n_clamp = grid_size;
    end
  end

  // stage 0 capture
  always_comb begin
    s0_nxt.x    = pos_x;
    s0_nxt.y    = pos_y;
    s0_nxt.z    = pos_z;
    s0_nxt.n    = n_clamp;
    s0_nxt.mode = shape_mode;
  end

  // stage 1 offsets and bounds
  always_comb begin
    s1_nxt.ax   = dbl_abs(s0_r.x, s0_r.n);
    s1_nxt.ay   = dbl_abs(s0_r.y, s0_r.n);
    s1_nxt.az   = dbl_abs(s0_r.z, s0_r.n);
    s1_nxt.c2   = s0_r.n - 6'd1;
    s1_nxt.n    = s0_r.n;
    s1_nxt.yrem = s0_r.n - {1'b0, s0_r.y};
    s1_nxt.inr  = ({1'b0, s0_r.x} < s0_r.n) && ({1'b0, s0_r.y} < s0_r.n) &&
                  ({1'b0, s0_r.z} < s0_r.n);
    s1_nxt.mode = s0_r.mode;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
    if (en[1]) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

/* hdl/vsmt_geom.sv */
// geometry stages: squares, pyramid and cross tests, radial sums
module vsmt_geom (
  input  logic          clk,
  input  logic [1:0]    en,
  input  vsmt_pkg::s1_t s1,
  output vsmt_pkg::s3_t s3
);
  import vsmt_pkg::*;

  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  logic bx, by, bz;

  // cross arm test 25*a <= 8*c2 + 25
  function automatic logic arm_ok(input logic [GRID_W-1:0] a,
                                  input logic [GRID_W-1:0] c2);
    logic [ARM_W-1:0] lhs;
    logic [ARM_W-1:0] rhs;
    lhs = {5'd0, a} * ARM_W'(ARM_MUL);
    rhs = {2'b00, c2, 3'b000} + ARM_W'(ARM_MUL);
    return lhs <= rhs;
  endfunction

  // stage 2 squares and simple shapes
  always_comb begin
    bx = arm_ok(s1.ax, s1.c2);
    by = arm_ok(s1.ay, s1.c2);
    bz = arm_ok(s1.az, s1.c2);
    s2_nxt.axsq = {6'd0, s1.ax} * {6'd0, s1.ax};
    s2_nxt.aysq = {6'd0, s1.ay} * {6'd0, s1.ay};
    s2_nxt.azsq = {6'd0, s1.az} * {6'd0, s1.az};
    s2_nxt.c2sq = {6'd0, s1.c2} * {6'd0, s1.c2};
    s2_nxt.nsq  = {6'd0, s1.n} * {6'd0, s1.n};
    s2_nxt.inr  = s1.inr;
    s2_nxt.pyr  = (s1.ax <= s1.yrem) && (s1.az <= s1.yrem);
    s2_nxt.crs  = (by & bz) | (bx & bz) | (bx & by);
    s2_nxt.mode = s1.mode;
  end

  // stage 3 radial sums
  always_comb begin
    s3_nxt.s    = {1'b0, s2_r.axsq} + {1'b0, s2_r.azsq};
    s3_nxt.t    = {2'b00, s2_r.axsq} + {2'b00, s2_r.azsq} + {2'b00, s2_r.aysq};
    s3_nxt.c2sq = s2_r.c2sq;
    s3_nxt.nsq  = s2_r.nsq;
    s3_nxt.inr  = s2_r.inr;
    s3_nxt.pyr  = s2_r.pyr;
    s3_nxt.crs  = s2_r.crs;
    s3_nxt.mode = s2_r.mode;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2_r <= s2_nxt;
    end
    if (en[1]) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

/* hdl/vsmt_torus.sv */
// radial stages: sphere, cylinder and ring compares, torus products
module vsmt_torus (
  input  logic          clk,
  input  logic [1:0]    en,
  input  vsmt_pkg::s3_t s3,
  output vsmt_pkg::s5_t s5
);
  import vsmt_pkg::*;

  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  logic [RNG_W-1:0] ring_s;
  logic [RNG_W-1:0] ring_c;

  // stage 4 torus terms and radial compares
  always_comb begin
    ring_s      = {9'd0, s3.s} * RNG_W'(RING_S);
    ring_c      = {10'd0, s3.c2sq} * RNG_W'(RING_C);
    s4_nxt.l    = {12'd0, s3.t} * L_W'(TOR_L_T) + {14'd0, s3.c2sq} * L_W'(TOR_L_C);
    s4_nxt.k    = {24'd0, s3.c2sq} * K_W'(TOR_K);
    s4_nxt.s    = s3.s;
    s4_nxt.inr  = s3.inr;
    s4_nxt.pyr  = s3.pyr;
    s4_nxt.crs  = s3.crs;
    s4_nxt.sph  = s3.t <= {2'b00, s3.nsq};
    s4_nxt.cyl  = s3.s <= {1'b0, s3.nsq};
    s4_nxt.rng  = (s3.s <= {1'b0, s3.nsq}) && (ring_s >= ring_c);
    s4_nxt.mode = s3.mode;
  end

  // stage 5 torus products
  always_comb begin
    s5_nxt.lsq  = {26'd0, s4_r.l} * {26'd0, s4_r.l};
    s5_nxt.rhs  = {13'd0, s4_r.k} * {36'd0, s4_r.s};
    s5_nxt.inr  = s4_r.inr;
    s5_nxt.pyr  = s4_r.pyr;
    s5_nxt.crs  = s4_r.crs;
    s5_nxt.sph  = s4_r.sph;
    s5_nxt.cyl  = s4_r.cyl;
    s5_nxt.rng  = s4_r.rng;
    s5_nxt.mode = s4_r.mode;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_r <= s4_nxt;
    end
    if (en[1]) begin
      s5_r <= s5_nxt;
    end
  end

  assign s5 = s5_r;

endmodule
